@@ design/r2fft_pkg.sv @@
// Shared types, constants and elaboration-time helpers for the radix-2 FFT engine.
// Holds the payload structs, the controller-to-datapath command struct and the
// twiddle table generator. No dependencies.
package r2fft_pkg;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] sample_real;
    logic signed [15:0] sample_imag;
  } fft_in_t;

  typedef struct packed {
    logic signed [31:0] bin_real;
    logic signed [31:0] bin_imag;
    logic               last_bin;
  } fft_out_t;

  typedef struct packed {
    logic rd_en;
    logic tw_en;
    logic cap_a;
    logic mul_en;
    logic cplx_en;
    logic bfy_en;
    logic we;
    logic wsel_load;
    logic wsel_b;
    logic inverse;
  } dp_cmd_t;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  localparam logic CFG_INVERSE = 1'b0;
  localparam logic CFG_LOG2    = 1'b1;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  localparam longint unsigned TS_DIV [6] = '{6, 20, 42, 72, 110, 156};
  localparam longint unsigned TC_DIV [6] = '{2, 12, 30, 56, 90, 132};

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Rounds a Q30 value half away from zero to tb bits and clamps symmetrically.
  function automatic longint quant(input longint v, input int tb);
    longint          lim;
    longint unsigned mag;
    longint          t;
    lim = (longint'(1) <<< (tb - 1)) - 1;
    mag = longint'(v < 0 ? -v : v);
    t   = longint'((mag + (64'd1 << (30 - tb))) >> (31 - tb));
    if (t > lim) t = lim;
    return (v < 0) ? -t : t;
  endfunction

  // Entry k of the half-circle table: {cos, sin}, each sign-extended to 32 bits.
  function automatic logic [63:0] twiddle(input int k, input int lmax, input int tb);
    longint unsigned maxn, quarter, q, r, rr, ang, x2, ts, tc;
    longint          ss, cs, c, s, cc, sn, tmp;
    bit              swap;
    logic [31:0]     qc, qs;
    maxn    = 64'd1 << lmax;
    quarter = maxn >> 2;
    q       = longint'(k) >> (lmax - 2);
    r       = longint'(k) & (quarter - 1);
    swap    = (2 * r > quarter);
    rr      = swap ? quarter - r : r;
    ang     = (2 * PI_Q30 * rr + (maxn >> 1)) >> lmax;
    x2      = (ang * ang + (64'd1 << 29)) >> 30;
    ts = ang;
    tc = ONE_Q30;
    ss = longint'(ang);
    cs = longint'(ONE_Q30);
    for (int n = 1; n <= 6; n++) begin
      ts = ((ts * x2) >> 30) / TS_DIV[n-1];
      tc = ((tc * x2) >> 30) / TC_DIV[n-1];
      if (n % 2 == 1) begin
        ss = ss - longint'(ts);
        cs = cs - longint'(tc);
      end else begin
        ss = ss + longint'(ts);
        cs = cs + longint'(tc);
      end
    end
    c = cs;
    s = ss;
    if (swap) begin
      tmp = c;
      c   = s;
      s   = tmp;
    end
    case (q & 3)
      0:       begin cc = c;  sn = s;  end
      1:       begin cc = -s; sn = c;  end
      2:       begin cc = -c; sn = -s; end
      default: begin cc = s;  sn = -c; end
    endcase
    qc = 32'(quant(cc, tb));
    qs = 32'(quant(sn, tb));
    return {qc, qs};
  endfunction

endpackage

@@ design/r2fft_ctrl.sv @@
// Controller of the FFT engine: configuration registers, frame counters and the
// butterfly sequencer. Depends on r2fft_pkg; drives r2fft_dp by command signals.
module r2fft_ctrl import r2fft_pkg::*; #(
  parameter int LMAX = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [3:0]      cfg_data_i,
  input  logic            start,
  input  logic            kind_i,
  output logic            busy,
  output dp_cmd_t         cmd_o,
  output logic [LMAX-1:0] raddr_o,
  output logic [LMAX-1:0] waddr_o,
  output logic [LMAX-2:0] tw_addr_o,
  output logic            out_valid_o,
  output logic            out_last_o
);

  localparam int AW = LMAX;
  localparam int CW = LMAX + 1;
  localparam int SW = $clog2(LMAX);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RA   = 3'd1;
  localparam logic [2:0] S_RB   = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_CPLX = 3'd4;
  localparam logic [2:0] S_BFY  = 3'd5;
  localparam logic [2:0] S_WA   = 3'd6;
  localparam logic [2:0] S_WB   = 3'd7;

  logic [2:0]    state_q, state_d;
  logic          inv_q, inv_d;
  logic [3:0]    lg_q, lg_d;
  logic [CW-1:0] load_cnt_q, load_cnt_d;
  logic [CW-1:0] read_cnt_q, read_cnt_d;
  logic          rdy_q, rdy_d;
  logic [SW-1:0] stage_q, stage_d;
  logic [AW-2:0] bfly_q, bfly_d;
  logic          vld_q, vld_d;
  logic          last_q, last_d;

  logic [3:0]    lg_eff;
  logic [CW-1:0] n_pts;
  logic [CW-1:0] base_cnt;
  logic [CW-1:0] next_cnt;
  logic [AW-1:0] rev_idx;
  logic [AW-1:0] mask;
  logic [AW-1:0] k_ext;
  logic [AW-1:0] ia, ib;
  logic [AW-1:0] tw_full;
  logic          accept;

  always_comb begin
    if (lg_q == 4'd0) lg_eff = 4'd1;
    else if (int'(lg_q) > LMAX) lg_eff = 4'(LMAX);
    else lg_eff = lg_q;
  end

  assign n_pts    = CW'(1) << lg_eff;
  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign base_cnt = rdy_q ? '0 : load_cnt_q;
  assign next_cnt = base_cnt + CW'(1);

  always_comb begin
    rev_idx = '0;
    for (int b = 0; b < AW; b++) begin
      if (b < int'(lg_eff)) rev_idx[b] = base_cnt[int'(lg_eff) - 1 - b];
    end
  end

  // Butterfly k of a stage pairs the entries that differ only in bit 'stage'.
  assign mask    = (AW'(1) << stage_q) - AW'(1);
  assign k_ext   = {1'b0, bfly_q};
  assign ia      = ((k_ext & ~mask) << 1) | (k_ext & mask);
  assign ib      = ia | (AW'(1) << stage_q);
  assign tw_full = (k_ext & mask) << (AW - 1 - int'(stage_q));

  always_comb begin
    state_d    = state_q;
    inv_d      = inv_q;
    lg_d       = lg_q;
    load_cnt_d = load_cnt_q;
    read_cnt_d = read_cnt_q;
    rdy_d      = rdy_q;
    stage_d    = stage_q;
    bfly_d     = bfly_q;
    vld_d      = 1'b0;
    last_d     = 1'b0;
    cmd_o      = '0;
    cmd_o.inverse = inv_q;
    raddr_o    = ia;
    waddr_o    = ia;
    tw_addr_o  = tw_full[AW-2:0];

    case (state_q)
      S_IDLE: begin
        if (accept && kind_i == KIND_LOAD) begin
          cmd_o.we        = 1'b1;
          cmd_o.wsel_load = 1'b1;
          waddr_o         = rev_idx;
          if (next_cnt >= n_pts) begin
            load_cnt_d = '0;
            read_cnt_d = '0;
            rdy_d      = 1'b0;
            stage_d    = '0;
            bfly_d     = '0;
            state_d    = S_RA;
          end else begin
            load_cnt_d = next_cnt;
            if (rdy_q) begin
              rdy_d      = 1'b0;
              read_cnt_d = '0;
            end
          end
        end else if (accept && kind_i == KIND_FETCH && rdy_q) begin
          cmd_o.rd_en = 1'b1;
          raddr_o     = read_cnt_q[AW-1:0];
          vld_d       = 1'b1;
          last_d      = (read_cnt_q == n_pts - CW'(1));
          if (read_cnt_q + CW'(1) >= n_pts) begin
            read_cnt_d = '0;
            rdy_d      = 1'b0;
          end else begin
            read_cnt_d = read_cnt_q + CW'(1);
          end
        end
      end
      S_RA: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.tw_en = 1'b1;
        state_d     = S_RB;
      end
      S_RB: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.cap_a = 1'b1;
        raddr_o     = ib;
        state_d     = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_CPLX;
      end
      S_CPLX: begin
        cmd_o.cplx_en = 1'b1;
        state_d       = S_BFY;
      end
      S_BFY: begin
        cmd_o.bfy_en = 1'b1;
        state_d      = S_WA;
      end
      S_WA: begin
        cmd_o.we = 1'b1;
        state_d  = S_WB;
      end
      S_WB: begin
        cmd_o.we     = 1'b1;
        cmd_o.wsel_b = 1'b1;
        waddr_o      = ib;
        state_d      = S_RA;
        if (k_ext == (n_pts[AW:1] - AW'(1))) begin
          bfly_d = '0;
          if (stage_q == SW'(lg_eff - 4'd1)) begin
            state_d = S_IDLE;
            rdy_d   = 1'b1;
          end else begin
            stage_d = stage_q + SW'(1);
          end
        end else begin
          bfly_d = bfly_q + (AW-1)'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INVERSE: inv_d = cfg_data_i[0];
        CFG_LOG2: begin
          lg_d       = cfg_data_i;
          load_cnt_d = '0;
          read_cnt_d = '0;
          rdy_d      = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      inv_q      <= 1'b0;
      lg_q       <= 4'd10;
      load_cnt_q <= '0;
      read_cnt_q <= '0;
      rdy_q      <= 1'b0;
      stage_q    <= '0;
      bfly_q     <= '0;
      vld_q      <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      inv_q      <= inv_d;
      lg_q       <= lg_d;
      load_cnt_q <= load_cnt_d;
      read_cnt_q <= read_cnt_d;
      rdy_q      <= rdy_d;
      stage_q    <= stage_d;
      bfly_q     <= bfly_d;
      vld_q      <= vld_d;
      last_q     <= last_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_last_o  = last_q;

endmodule

@@ design/r2fft_dp.sv @@
// Datapath of the FFT engine: sample memory, twiddle table and butterfly unit.
// Depends on r2fft_pkg; steered cycle by cycle by r2fft_ctrl.
module r2fft_dp import r2fft_pkg::*; #(
  parameter int LMAX = 10,
  parameter int TB   = 16
) (
  input  logic               clk_i,
  input  dp_cmd_t            cmd_i,
  input  logic [LMAX-1:0]    raddr_i,
  input  logic [LMAX-1:0]    waddr_i,
  input  logic [LMAX-2:0]    tw_addr_i,
  input  logic signed [15:0] load_re_i,
  input  logic signed [15:0] load_im_i,
  output logic [63:0]        rdata_o
);

  localparam int DEPTH = 1 << LMAX;
  localparam int HALF  = DEPTH / 2;
  localparam int PW    = 32 + TB + 1;

  logic [63:0] mem [DEPTH];
  logic [63:0] rdata_q;
  logic [63:0] rom [HALF];
  logic [63:0] tw_q;
  logic [63:0] a_q;
  logic [63:0] wdata;

  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [31:0]   o_re_q, o_im_q;
  logic signed [31:0]   s_re_q, s_im_q, d_re_q, d_im_q;

  logic signed [TB-1:0] w_re;
  logic signed [TB:0]   w_im;
  logic signed [31:0]   b_re, b_im, a_re, a_im;
  logic signed [63:0]   t_re, t_im;
  logic signed [32:0]   sum_re, sum_im, dif_re, dif_im;

  for (genvar k = 0; k < HALF; k++) begin : g_rom
    localparam logic [63:0] W = twiddle(k, LMAX, TB);
    assign rom[k] = W;
  end

  assign w_re = tw_q[32 +: TB];
  assign w_im = cmd_i.inverse ? (TB+1)'(signed'(tw_q[0 +: TB]))
                              : -(TB+1)'(signed'(tw_q[0 +: TB]));
  assign b_re = rdata_q[63:32];
  assign b_im = rdata_q[31:0];
  assign a_re = a_q[63:32];
  assign a_im = a_q[31:0];

  // Round to nearest with ties up, then drop the twiddle fraction bits.
  assign t_re = (64'(p_rr_q) - 64'(p_ii_q) + (64'sd1 <<< (TB - 2))) >>> (TB - 1);
  assign t_im = (64'(p_ri_q) + 64'(p_ir_q) + (64'sd1 <<< (TB - 2))) >>> (TB - 1);

  assign sum_re = 33'(a_re) + 33'(o_re_q);
  assign sum_im = 33'(a_im) + 33'(o_im_q);
  assign dif_re = 33'(a_re) - 33'(o_re_q);
  assign dif_im = 33'(a_im) - 33'(o_im_q);

  function automatic logic signed [31:0] fin(input logic signed [32:0] v, input logic halve);
    logic signed [33:0] h;
    h = (34'(v) + 34'sd1) >>> 1;
    return halve ? sat32(64'(h)) : sat32(64'(v));
  endfunction

  always_comb begin
    if (cmd_i.wsel_load) wdata = {32'(load_re_i), 32'(load_im_i)};
    else if (cmd_i.wsel_b) wdata = {d_re_q, d_im_q};
    else wdata = {s_re_q, s_im_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) mem[waddr_i] <= wdata;
    if (cmd_i.rd_en) rdata_q <= mem[raddr_i];
    if (cmd_i.tw_en) tw_q <= rom[tw_addr_i];
    if (cmd_i.cap_a) a_q <= rdata_q;
    if (cmd_i.mul_en) begin
      p_rr_q <= PW'(w_re) * PW'(b_re);
      p_ii_q <= PW'(w_im) * PW'(b_im);
      p_ri_q <= PW'(w_re) * PW'(b_im);
      p_ir_q <= PW'(w_im) * PW'(b_re);
    end
    if (cmd_i.cplx_en) begin
      o_re_q <= sat32(t_re);
      o_im_q <= sat32(t_im);
    end
    if (cmd_i.bfy_en) begin
      s_re_q <= fin(sum_re, !cmd_i.inverse);
      s_im_q <= fin(sum_im, !cmd_i.inverse);
      d_re_q <= fin(dif_re, !cmd_i.inverse);
      d_im_q <= fin(dif_im, !cmd_i.inverse);
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/radix2_fft_engine_core.sv @@
// Top level of the radix-2 FFT engine: ties the controller to the datapath.
// Depends on r2fft_pkg, r2fft_ctrl and r2fft_dp.
//
// Usage: an item is taken when start is high and busy is low. A load item
// writes the next sample at its bit-reversed address; the load that
// completes the frame starts the in-place transform, and busy stays
// high while each butterfly steps through read, multiply, round, add
// and write in turn. A fetch item, when results are held, reads the
// next bin in natural order; the bin is shown on result_o with
// result_valid_o high for exactly one cycle, the cycle after the fetch
// is taken. Outside a transform, fetches and loads may be issued back
// to back. A fetch with no results gives nothing.
// The receiver cannot hold results off; each bin is shown once.
// Configuration writes (index 0 inverse mode, index 1 log2 size) are taken
// at any edge with cfg_we_i high; a size write drops a partial frame and
// unread results. Reset clears counters and registers (size 10, forward);
// memory contents are undefined until loaded.
module radix2_fft_engine_core import r2fft_pkg::*; #(
  parameter int LOG2_MAX_POINTS = 10,
  parameter int TWIDDLE_BITS    = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_idx_i,
  input  logic [3:0] cfg_data_i,
  input  logic     start,
  input  fft_in_t  item_i,
  output logic     busy,
  output logic     result_valid_o,
  output fft_out_t result_o
);

  dp_cmd_t                    cmd;
  logic [LOG2_MAX_POINTS-1:0] raddr, waddr;
  logic [LOG2_MAX_POINTS-2:0] tw_addr;
  logic [63:0]                rdata;
  logic                       last;

  r2fft_ctrl #(.LMAX(LOG2_MAX_POINTS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .start       (start),
    .kind_i      (item_i.kind),
    .busy        (busy),
    .cmd_o       (cmd),
    .raddr_o     (raddr),
    .waddr_o     (waddr),
    .tw_addr_o   (tw_addr),
    .out_valid_o (result_valid_o),
    .out_last_o  (last)
  );

  r2fft_dp #(.LMAX(LOG2_MAX_POINTS), .TB(TWIDDLE_BITS)) u_dp (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .raddr_i   (raddr),
    .waddr_i   (waddr),
    .tw_addr_i (tw_addr),
    .load_re_i (item_i.sample_real),
    .load_im_i (item_i.sample_imag),
    .rdata_o   (rdata)
  );

  assign result_o.bin_real = rdata[63:32];
  assign result_o.bin_imag = rdata[31:0];
  assign result_o.last_bin = last;

endmodule

@@ design/r2fft_chk.sv @@
// Port-level checker for the FFT engine, bound to the top level.
// Depends on r2fft_pkg.
module r2fft_chk import r2fft_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input fft_in_t  item_i,
  input logic     busy,
  input logic     result_valid_o
);

  // A bin only follows a fetch transaction taken in the previous cycle.
  a_res_after_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy && item_i.kind == KIND_FETCH))
    else $error("result without a preceding fetch");

  // A load never produces a bin.
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.kind == KIND_LOAD) |=> !result_valid_o)
    else $error("result after a load");

  // The transform only starts from a load transaction.
  a_busy_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && item_i.kind == KIND_LOAD))
    else $error("busy without a completing load");

  // No bin is shown while the transform runs.
  a_no_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result during transform");

endmodule

bind radix2_fft_engine_core r2fft_chk u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .item_i         (item_i),
  .busy           (busy),
  .result_valid_o (result_valid_o)
);

@@ test/r2fft_checker.sv @@
// Checker for the radix-2 FFT engine: watches the configuration, item and
// result channels, predicts every bin and compares it. Depends on r2fft_pkg.
module r2fft_checker import r2fft_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_idx_i,
  input  logic [3:0] cfg_data_i,
  input  logic     start,
  input  logic     busy,
  input  fft_in_t  item_i,
  input  logic     result_valid_o,
  input  fft_out_t result_o,
  output int       fail_count,
  output int       bins_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXLG = 10;
  localparam int MAXN  = 1 << MAXLG;

  longint   tw_cos [MAXN/2];
  longint   tw_sin [MAXN/2];
  longint   mem_re [MAXN];
  longint   mem_im [MAXN];
  int       load_cnt;
  int       read_cnt;
  bit       bins_held;
  bit       inverse;
  int       size_code;
  fft_out_t bins_due [$];

  // Octant cosine and sine by a truncated Taylor series in Q30.
  function automatic void octant_cs(input longint unsigned x, output longint c,
                                    output longint s);
    longint unsigned x2, ts, tc;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    ts = x;
    tc = 64'd1 << 30;
    s  = longint'(x);
    c  = longint'(64'd1 << 30);
    for (int n = 1; n <= 6; n++) begin
      ts = ((ts * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      tc = ((tc * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        s -= longint'(ts);
        c -= longint'(tc);
      end else begin
        s += longint'(ts);
        c += longint'(tc);
      end
    end
  endfunction

  function automatic longint to_q15(input longint v);
    longint unsigned m;
    longint t;
    m = (v < 0) ? -v : v;
    t = longint'((m + (64'd1 << 14)) >> 15);
    if (t > 32767) t = 32767;
    return (v < 0) ? -t : t;
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  initial begin
    longint unsigned quarter, q, r, rr, ang;
    longint c, s, t;
    bit swap;
    quarter = MAXN / 4;
    for (int k = 0; k < MAXN / 2; k++) begin
      q    = k / quarter;
      r    = k % quarter;
      swap = (2 * r > quarter);
      rr   = swap ? quarter - r : r;
      ang  = (2 * PI_Q30 * rr + MAXN / 2) >> MAXLG;
      octant_cs(ang, c, s);
      if (swap) begin
        t = c;
        c = s;
        s = t;
      end
      case (q)
        0: begin tw_cos[k] = to_q15(c);  tw_sin[k] = to_q15(s);  end
        1: begin tw_cos[k] = to_q15(-s); tw_sin[k] = to_q15(c);  end
        2: begin tw_cos[k] = to_q15(-c); tw_sin[k] = to_q15(-s); end
        default: begin tw_cos[k] = to_q15(s); tw_sin[k] = to_q15(-c); end
      endcase
    end
  end

  function automatic int active_log2();
    if (size_code < 1) return 1;
    if (size_code > MAXLG) return MAXLG;
    return size_code;
  endfunction

  function automatic void run_fft(input int lg);
    int n, h, stp, ia, ib, ti;
    longint wr, wi, ar, ai, br, bi, pr, pi, sr, si, dr, di;
    n = 1 << lg;
    for (int len = 2; len <= n; len <<= 1) begin
      stp = MAXN / len;
      h   = len / 2;
      for (int base = 0; base < n; base += len) begin
        for (int j = 0; j < h; j++) begin
          ia = base + j;
          ib = base + j + h;
          ti = (j * stp) & (MAXN / 2 - 1);
          wr = tw_cos[ti];
          wi = inverse ? tw_sin[ti] : -tw_sin[ti];
          ar = mem_re[ia];
          ai = mem_im[ia];
          br = mem_re[ib];
          bi = mem_im[ib];
          pr = clip32((wr * br - wi * bi + 16384) >>> 15);
          pi = clip32((wr * bi + wi * br + 16384) >>> 15);
          sr = ar + pr;
          si = ai + pi;
          dr = ar - pr;
          di = ai - pi;
          if (!inverse) begin
            sr = (sr + 1) >>> 1;
            si = (si + 1) >>> 1;
            dr = (dr + 1) >>> 1;
            di = (di + 1) >>> 1;
          end
          mem_re[ia] = clip32(sr);
          mem_im[ia] = clip32(si);
          mem_re[ib] = clip32(dr);
          mem_im[ib] = clip32(di);
        end
      end
    end
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t bin field %s: got %0d, want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic predict_item(input fft_in_t it);
    int lg, n, addr;
    fft_out_t b;
    lg = active_log2();
    n  = 1 << lg;
    if (it.kind == KIND_LOAD) begin
      if (bins_held) begin
        bins_held = 0;
        read_cnt  = 0;
        load_cnt  = 0;
      end
      addr = 0;
      for (int i = 0; i < lg; i++) addr = (addr << 1) | ((load_cnt >> i) & 1);
      mem_re[addr] = longint'(it.sample_real);
      mem_im[addr] = longint'(it.sample_imag);
      load_cnt++;
      if (load_cnt >= n) begin
        run_fft(lg);
        load_cnt  = 0;
        read_cnt  = 0;
        bins_held = 1;
      end
    end else if (bins_held) begin
      b.bin_real = 32'(mem_re[read_cnt]);
      b.bin_imag = 32'(mem_im[read_cnt]);
      b.last_bin = (read_cnt == n - 1);
      bins_due.push_back(b);
      read_cnt++;
      if (read_cnt >= n) begin
        read_cnt  = 0;
        bins_held = 0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fft_out_t want;
    if (!rst_ni) begin
      load_cnt     = 0;
      read_cnt     = 0;
      bins_held    = 0;
      inverse      = 0;
      size_code    = 10;
      fail_count   = 0;
      bins_pending <= 0;
      bins_due.delete();
    end else begin
      // A bin shown now comes from an earlier fetch, so it is checked first.
      if (result_valid_o) begin
        if (bins_due.size() == 0) begin
          $display("%0t bin with no fetch outstanding", $realtime);
          fail_count++;
        end else begin
          want = bins_due.pop_front();
          if (result_o.bin_real !== want.bin_real)
            report("bin_real", result_o.bin_real, want.bin_real);
          if (result_o.bin_imag !== want.bin_imag)
            report("bin_imag", result_o.bin_imag, want.bin_imag);
          if (result_o.last_bin !== want.last_bin)
            report("last_bin", result_o.last_bin, want.last_bin);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_INVERSE) begin
          inverse = cfg_data_i[0];
        end else begin
          size_code = cfg_data_i;
          load_cnt  = 0;
          read_cnt  = 0;
          bins_held = 0;
        end
      end
      if (start && !busy) predict_item(item_i);
      bins_pending <= bins_due.size();
    end
  end

endmodule

@@ test/tb_radix2_fft_engine_core.sv @@
// Testbench top for radix2_fft_engine_core: drives loads, fetches and register
// writes and gives the verdict. Depends on r2fft_pkg and r2fft_checker.
module tb_radix2_fft_engine_core import r2fft_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1950;
  localparam int CYCLE_LIMIT = 1500000;

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_we_i;
  logic     cfg_idx_i;
  logic [3:0] cfg_data_i;
  logic     start;
  fft_in_t  item_i;
  logic     busy;
  logic     result_valid_o;
  fft_out_t result_o;
  int       fail_count;
  int       bins_pending;
  int       sent;
  int       idle_pct;
  int       cur_lg;
  int       big_frames;
  int       cycles;

  radix2_fft_engine_core u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .start, .item_i, .busy, .result_valid_o, .result_o
  );

  r2fft_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start, .busy,
    .item_i, .result_valid_o, .result_o, .fail_count, .bins_pending
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("radix2_fft_engine_core: mismatch");
      $finish;
    end
  end

  // Issues one transaction and returns at the edge that accepted it.
  task automatic put(input logic kind, input logic [15:0] re, input logic [15:0] im);
    bit ok;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= '{kind: kind, sample_real: re, sample_imag: im};
    do begin
      @(negedge clk_i);
      ok = !busy;
      @(posedge clk_i);
    end while (!ok);
    sent++;
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    do @(posedge clk_i); while (bins_pending != 0 || busy);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input int value);
    wait_quiet();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= 4'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_LOG2) cur_lg = (value < 1) ? 1 : (value > 10) ? 10 : value;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return ($urandom_range(1) != 0) ? 16'h0000 : 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic load_samples(input int count);
    for (int i = 0; i < count; i++) put(KIND_LOAD, pick_sample(), pick_sample());
  endtask

  task automatic fetch_bins(input int count);
    for (int i = 0; i < count; i++) put(KIND_FETCH, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    int r, npts;
    sent       = 0;
    big_frames = 0;
    cur_lg     = 10;
    idle_pct   = 35;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_INVERSE;
    cfg_data_i = '0;
    start      = 1'b0;
    item_i     = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: size code zero acts as two points, full-scale samples.
    write_reg(CFG_LOG2, 0);
    put(KIND_LOAD, 16'h7fff, 16'h8000);
    put(KIND_LOAD, 16'h8000, 16'h7fff);
    fetch_bins(3);
    // Inverse mode, then a load during readout that drops the unread bin.
    write_reg(CFG_INVERSE, 1);
    write_reg(CFG_LOG2, 1);
    put(KIND_LOAD, 16'h8000, 16'h8000);
    put(KIND_LOAD, 16'h7fff, 16'h7fff);
    fetch_bins(1);
    put(KIND_LOAD, 16'd100, -16'sd100);
    // A mode change in the middle of a frame applies to that frame's transform.
    write_reg(CFG_INVERSE, 0);
    put(KIND_LOAD, 16'hffff, 16'h0001);
    fetch_bins(2);
    // A size write drops the partial frame.
    write_reg(CFG_LOG2, 2);
    load_samples(3);
    write_reg(CFG_LOG2, 2);
    load_samples(4);
    fetch_bins(4);

    while (sent < ITEM_TARGET) begin
      if (sent > ITEM_TARGET / 3) idle_pct = 71;
      if (sent > 2 * ITEM_TARGET / 3) idle_pct = 0;
      if ($urandom_range(3) == 0) write_reg(CFG_INVERSE, $urandom_range(1));
      // One full-size frame, read out only in part so the item count holds.
      if (big_frames == 0 && sent > 400) begin
        write_reg(CFG_LOG2, $urandom_range(10, 15));
        big_frames++;
        load_samples(1 << cur_lg);
        fetch_bins($urandom_range(1, 160));
        continue;
      end
      r = $urandom_range(99);
      if (r < 8) write_reg(CFG_LOG2, 0);
      else if (r < 60) write_reg(CFG_LOG2, $urandom_range(1, 5));
      else if (cur_lg > 5) write_reg(CFG_LOG2, $urandom_range(1, 5));
      npts = 1 << cur_lg;
      case ($urandom_range(9))
        0: load_samples($urandom_range(1, npts));
        1: begin
          load_samples(npts);
          fetch_bins($urandom_range(0, npts - 1));
        end
        2: begin
          fetch_bins($urandom_range(1, 2));
          load_samples(npts);
          fetch_bins(npts);
        end
        3: begin
          load_samples(npts);
          wait_quiet();
          fetch_bins(npts + $urandom_range(0, 2));
        end
        default: begin
          load_samples(npts);
          fetch_bins(npts);
        end
      endcase
    end

    start <= 1'b0;
    do @(posedge clk_i); while (bins_pending != 0);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("radix2_fft_engine_core: match");
    end else begin
      $display("radix2_fft_engine_core: mismatch");
    end
    $finish;
  end

endmodule
